// File: sv/sha256_pkg.sv
// Shared types, constants and round functions of the streaming SHA-256 hasher.
package sha256_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned HashWords  = 8;
	localparam int unsigned TotalW = 61;

	typedef logic [WordW-1:0] word_t;

	localparam word_t InitHash [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos  = 6'd56;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       put;       // write pad or msg byte at fill position, advance fill
		logic       put_pad;   // byte is the 0x80 / zero pad (pad_val selects)
		logic       pad_val;   // 1: 0x80, 0: zero
		logic       cnt_byte;  // advance byte total
		logic       put_len;   // write bit length into words 14 and 15
		logic       load;      // copy hash into working vars
		logic       round;     // run one round
		logic       fold;      // add working vars into hash
		logic       restart;   // back to initial hash, fill and byte counts cleared
		logic       clr_fill;  // fill count to zero
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] rnd;
	} sha_sts_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

endpackage

// File: sv/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher: controller plus datapath.
//
// channel | signals                                   | direction
// in      | valid ready msg_byte byte_present end_of_message | byte in
// out     | out_valid out_ready digest_word word_index last_word | 8 words out
//
// A byte is taken while ready; the 64th byte of a block then starts the
// load, 64 rounds (one per cycle through the single round unit) and fold.
// End of message writes the pad bytes and the length and runs one or two
// compressions, then eight output words at one per out_ready cycle.
// Reset sets the initial hash values and clears counts; no clearing pass.
// Input is not taken while a compression runs or digest words wait.
module sha256_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                ready,
	input  logic [7:0]          msg_byte,
	input  logic                byte_present,
	input  logic                end_of_message,
	output logic                out_valid,
	input  logic                out_ready,
	output sha256_pkg::word_t   digest_word,
	output logic [2:0]          word_index,
	output logic                last_word
);
	import sha256_pkg::*;

	sha_cmd_t cmd;
	sha_sts_t sts;

	// Hold the controller's sequencing separate from the arithmetic.
	sha256_ctrl u_ctrl (
		.clk, .arst_n, .valid, .ready, .byte_present, .end_of_message,
		.sts, .cmd, .out_valid, .out_ready, .out_index(word_index)
	);

	sha256_datapath u_dp (
		.clk, .arst_n, .cmd, .msg_byte, .rd_index(word_index), .sts,
		.rd_word(digest_word)
	);

	assign last_word = (word_index == 3'd7);

`ifndef NO_ASSERTIONS
	a_no_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(ready && out_valid)) else $error("ready while digest pending");
	a_round_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |-> !ready) else $error("round while ready");
	a_out_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> out_valid)
		else $error("digest burst broken");
`endif

endmodule

// File: sv/sha256_datapath.sv
// Datapath: block store, schedule window, round unit, hash words and counters.
module sha256_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha256_pkg::sha_cmd_t cmd,
	input  logic [7:0]           msg_byte,
	input  logic [2:0]           rd_index,
	output sha256_pkg::sha_sts_t sts,
	output sha256_pkg::word_t    rd_word
);
	import sha256_pkg::*;

	word_t            blk_q [BlockWords];
	word_t            win_q [BlockWords];
	word_t            hash_q [HashWords];
	word_t            v_q [HashWords];
	logic [5:0]       fill_q;
	logic [5:0]       rnd_q;
	logic [TotalW-1:0] total_q;

	logic [7:0]  byte_in;
	logic [3:0]  wsel;
	logic [4:0]  shamt;
	logic [3:0]  t4;
	word_t       w15, w2, w, s0, s1, ch, maj, t1, t2;
	logic [63:0] bits;

	assign byte_in = cmd.put_pad ? (cmd.pad_val ? PadByte : 8'h00) : msg_byte;
	assign wsel    = fill_q[5:2];
	assign shamt   = {2'(2'd3 - fill_q[1:0]), 3'd0};
	assign t4      = rnd_q[3:0];
	assign bits    = {total_q, 3'b000};

	always_comb begin
		w15 = win_q[4'(t4 - 4'd15)];
		w2  = win_q[4'(t4 - 4'd2)];
		if (rnd_q < 6'd16) begin
			w = blk_q[t4];
		end else begin
			w = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + win_q[4'(t4 - 4'd7)]
			  + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + win_q[t4];
		end
		s1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1  = v_q[7] + s1 + ch + RoundK[rnd_q] + w;
		s0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2  = s0 + maj;
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			if (fill_q[1:0] == 2'd0) begin
				blk_q[wsel] <= word_t'(byte_in) << shamt;
			end else begin
				blk_q[wsel] <= blk_q[wsel] | (word_t'(byte_in) << shamt);
			end
		end
		if (cmd.put_len) begin
			blk_q[14] <= bits[63:32];
			blk_q[15] <= bits[31:0];
		end
		if (cmd.round) begin
			win_q[t4] <= w;
		end
		if (cmd.load) begin
			for (int i = 0; i < HashWords; i++) v_q[i] <= hash_q[i];
		end else if (cmd.round) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HashWords; i++) hash_q[i] <= InitHash[i];
			fill_q  <= '0;
			rnd_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < HashWords; i++) hash_q[i] <= InitHash[i];
				fill_q  <= '0;
				total_q <= '0;
			end else begin
				if (cmd.fold) begin
					for (int i = 0; i < HashWords; i++) hash_q[i] <= hash_q[i] + v_q[i];
				end
				if (cmd.clr_fill) begin
					fill_q <= '0;
				end else if (cmd.put) begin
					fill_q <= fill_q + 6'd1;
				end
				if (cmd.cnt_byte) total_q <= total_q + TotalW'(1);
			end
			if (cmd.round) rnd_q <= rnd_q + 6'd1;
		end
	end

	assign sts.fill = fill_q;
	assign sts.rnd  = rnd_q;
	assign rd_word  = hash_q[rd_index];

endmodule

// File: sv/sha256_ctrl.sv
// Controller: sequences absorb, padding, compression and digest output.
module sha256_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 ready,
	input  logic                 byte_present,
	input  logic                 end_of_message,
	input  sha256_pkg::sha_sts_t sts,
	output sha256_pkg::sha_cmd_t cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           out_index
);
	import sha256_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_ROUND = 7'b0000100,
		ST_FOLD  = 7'b0001000,
		ST_PAD   = 7'b0010000,
		ST_LEN   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t     state_q;
	logic       fin_q;    // message closing: pad after compression
	logic       padded_q; // 0x80 already placed
	logic [2:0] idx_q;

	assign ready     = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_index = idx_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (valid && byte_present) begin
					cmd.put = 1'b1;
					cmd.cnt_byte = 1'b1;
				end
			end
			ST_LOAD:  cmd.load = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_FOLD: begin
				cmd.fold = 1'b1;
				cmd.clr_fill = 1'b1;
			end
			ST_PAD: begin
				cmd.put = 1'b1;
				cmd.put_pad = 1'b1;
				cmd.pad_val = !padded_q;
			end
			ST_LEN:   cmd.put_len = 1'b1;
			ST_OUT:   cmd.restart = out_ready && (idx_q == 3'd7);
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fin_q    <= 1'b0;
			padded_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (valid) begin
						fin_q    <= end_of_message;
						padded_q <= 1'b0;
						if (byte_present && sts.fill == 6'd63) begin
							state_q <= ST_LOAD;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_LOAD:  state_q <= ST_ROUND;
				ST_ROUND: if (sts.rnd == 6'd63) state_q <= ST_FOLD;
				ST_FOLD: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (padded_q && sts.fill >= LenPos) begin
						// length block just compressed
						state_q <= ST_OUT;
						idx_q   <= '0;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					padded_q <= 1'b1;
					// Zero-fill to 56 or, past it, to the end of the block.
					if (sts.fill == 6'd63) begin
						state_q <= ST_LOAD;
					end else if (sts.fill == LenPos - 6'd1 && padded_q) begin
						state_q <= ST_LEN;
					end else if (sts.fill == LenPos - 6'd1) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: state_q <= ST_LOAD;
				ST_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= ST_IDLE;
							fin_q   <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
